@@ rtl/multi_motor_pd_with_lock_and_stall_top_defines.svh @@
// Assertion macros used by the port-level checker.
// No dependencies.
`ifndef MULTI_MOTOR_PD_WITH_LOCK_AND_STALL_TOP_DEFINES_SVH
`define MULTI_MOTOR_PD_WITH_LOCK_AND_STALL_TOP_DEFINES_SVH
// implication checked on every clock edge outside reset
`define MMPD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// same but also checked during reset
`define MMPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ rtl/mmpd_pkg.sv @@
// Package for the multi-motor PD controller: payload types, register indexes.
// No dependencies.
`default_nettype none
package mmpd_pkg;
  typedef struct packed {
    logic               kind;
    logic [2:0]         target_motor;
    logic signed [31:0] target_value;
    logic signed [31:0] pos_m0;
    logic signed [31:0] pos_m1;
    logic signed [31:0] pos_m2;
    logic signed [31:0] pos_m3;
    logic signed [31:0] pos_m4;
    logic signed [31:0] pos_m5;
  } in_item_t;

  typedef struct packed {
    logic signed [11:0] drive_m0;
    logic signed [11:0] drive_m1;
    logic signed [11:0] drive_m2;
    logic signed [11:0] drive_m3;
    logic signed [11:0] drive_m4;
    logic signed [11:0] drive_m5;
    logic [5:0]         stall_flags;
  } out_item_t;

  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_LOCK   = 3'd1;
  localparam logic [2:0] REG_PWM    = 3'd2;
  localparam logic [2:0] REG_STALL  = 3'd3;
  localparam logic [2:0] REG_MAXT   = 3'd4;
  localparam logic [2:0] REG_KP     = 3'd5;
  localparam logic [2:0] REG_KD     = 3'd6;

  localparam int MaxMotors = 6;
  localparam logic signed [11:0] DriveMax = 12'sd2047;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_RD, ST_MUL, ST_PD, ST_SCALE, ST_LOCKDIV,
    ST_FIN, ST_STDIV, ST_AVG, ST_WB, ST_OUT
  } state_e;
endpackage
`default_nettype wire

@@ rtl/mmpd_ram.sv @@
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module mmpd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(Depth)-1:0] waddr_i,
  input  wire [Width-1:0]         wdata_i,
  input  wire [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]        rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

@@ rtl/mmpd_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
`default_nettype none
module mmpd_div #(
  parameter int Width = 36
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start_i,
  input  wire [Width-1:0]  num_i,
  input  wire [Width-1:0]  den_i,
  output logic             done_o,
  output logic [Width-1:0] quo_o
);
  localparam int CntW = $clog2(Width + 1);
  logic [Width-1:0] rem_q, rem_d, quo_q, quo_d, den_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic [Width:0]   trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, quo_q[Width-1]} - {1'b0, den_q};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      cnt_d  = CntW'(Width);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[Width]) begin
        rem_d = trial[Width-1:0];
        quo_d = {quo_q[Width-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[Width-2:0], quo_q[Width-1]};
        quo_d = {quo_q[Width-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = busy_q && (cnt_q == CntW'(1));
  assign quo_o  = quo_d;
endmodule
`default_nettype wire

@@ rtl/multi_motor_pd_with_lock_and_stall_top.sv @@
// Channel   | Dir | Handshake         | Payload
// in        | in  | in_valid/in_stall | mmpd_pkg::in_item_t
// out       | out | out_valid/out_stall | mmpd_pkg::out_item_t
// cfg       | in  | cfg_valid/cfg_ready | index 3b, data 64b
// A tick visits each motor in turn: an enabled one runs RD, MUL, PD, SCALE,
// LOCKDIV, FIN, STDIV, AVG and WB, a disabled one RD and WB; then OUT and idle.
// Per enabled motor the shared 36-bit serial divider runs twice (lock mean, stall).
// Items are held off until a tick is back in idle. After reset a clearing pass
// zeroes all NUM_MOTORS*HISTORY_DEPTH history entries; no item is taken then.
// The result waits in an output register; the next item is taken meanwhile.
// Depends on mmpd_pkg, mmpd_ram, mmpd_div.
`default_nettype none
module multi_motor_pd_with_lock_and_stall_top #(
  parameter int NUM_MOTORS    = 6,
  parameter int HISTORY_DEPTH = 40
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  mmpd_pkg::in_item_t   in_data_i,
  output logic                 out_valid,
  input  wire                  out_stall,
  output mmpd_pkg::out_item_t  out_data_o,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire [2:0]            cfg_index_i,
  input  wire [63:0]           cfg_data_i
);
  localparam int MW = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
  localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int SD = NUM_MOTORS * HISTORY_DEPTH;
  localparam int SW = $clog2(SD);
  localparam int DW = 36;

  // configuration
  logic [5:0]  en_q;
  logic [14:0] lock_q;
  logic [10:0] pwm_q, slim_q;
  logic [19:0] maxt_q;
  logic [59:0] kp_q, kd_q;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= '0; lock_q <= '0; pwm_q <= 11'd512; slim_q <= 11'd512;
      maxt_q <= '0; kp_q <= '0; kd_q <= '0;
    end else if (cfg_valid) begin
      case (cfg_index_i)
        mmpd_pkg::REG_ENABLE: en_q   <= cfg_data_i[5:0];
        mmpd_pkg::REG_LOCK:   lock_q <= cfg_data_i[14:0];
        mmpd_pkg::REG_PWM:    pwm_q  <= cfg_data_i[10:0];
        mmpd_pkg::REG_STALL:  slim_q <= cfg_data_i[10:0];
        mmpd_pkg::REG_MAXT:   maxt_q <= cfg_data_i[19:0];
        mmpd_pkg::REG_KP:     kp_q   <= cfg_data_i[59:0];
        mmpd_pkg::REG_KD:     kd_q   <= cfg_data_i[59:0];
        default: ;
      endcase
    end
  end

  // small per-motor state kept in flops (NUM_MOTORS entries each)
  logic [19:0]        tgt_q  [NUM_MOTORS];
  logic signed [31:0] last_q [NUM_MOTORS];
  logic [HW-1:0]      ridx_q [NUM_MOTORS];
  logic [16:0]        ssum_q [NUM_MOTORS];

  // tick working registers
  mmpd_pkg::state_e   st_q, st_d;
  logic signed [31:0] pos_q [NUM_MOTORS];
  logic [MW-1:0]      m_q;
  logic [SW-1:0]      clr_q;
  logic signed [47:0] pkp_q, pkd_q;
  logic signed [48:0] pd_q;
  logic signed [12:0] sc_q;
  logic signed [35:0] lsum_q;
  logic [2:0]         lcnt_q;
  logic signed [36:0] fin_q;
  logic signed [11:0] p_q;
  logic [10:0]        stl_q;
  logic [10:0]        old_q;
  logic               lneg_q;
  mmpd_pkg::out_item_t res_q;
  logic [11:0]        drv_q [mmpd_pkg::MaxMotors];
  logic [5:0]         flg_q;
  logic               ov_q, ov_d;

  // helper combinational values
  logic signed [32:0] pm, last_m, err, derr, dx;
  logic [9:0]         kp_m, kd_m;
  logic               on_m;
  logic signed [35:0] lsum_c;
  logic [2:0]         lcnt_c;

  always_comb begin
    pm     = 33'(pos_q[m_q]);
    last_m = 33'(last_q[m_q]);
    err    = $signed({13'b0, tgt_q[m_q]}) - pm;
    derr   = last_m - pm;
    kp_m   = kp_q[10*m_q +: 10];
    kd_m   = kd_q[10*m_q +: 10];
    on_m   = en_q[m_q];
    lsum_c = '0;
    lcnt_c = '0;
    for (int o = 0; o < NUM_MOTORS; o++) begin
      int lo, hi, b;
      lo = (o < int'(m_q)) ? o : int'(m_q);
      hi = (o < int'(m_q)) ? int'(m_q) : o;
      b  = lo * (2 * NUM_MOTORS - lo - 1) / 2 + (hi - lo - 1);
      if (o != int'(m_q) && en_q[o] && b >= 0 && b < 15 && lock_q[b]) begin
        lsum_c = lsum_c + 36'(pos_q[o]) - 36'(pos_q[m_q]);
        lcnt_c = lcnt_c + 3'd1;
      end
    end
    dx = pm - last_m;
  end

  // history memory
  logic          ram_we;
  logic [SW-1:0] ram_wa, ram_ra, slot;
  logic [10:0]   ram_wd, ram_rd;
  assign slot = SW'(m_q * HISTORY_DEPTH + ridx_q[m_q]);

  mmpd_ram #(.Width(11), .Depth(SD)) u_hist (
    .clk_i(clk_i), .we_i(ram_we), .waddr_i(ram_wa), .wdata_i(ram_wd),
    .raddr_i(ram_ra), .rdata_o(ram_rd)
  );

  // divider
  logic          dv_start, dv_done;
  logic [DW-1:0] dv_num, dv_den, dv_quo;
  mmpd_div #(.Width(DW)) u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(dv_start), .num_i(dv_num),
    .den_i(dv_den), .done_o(dv_done), .quo_o(dv_quo)
  );

  logic in_acc, out_acc, last_m_flag;
  assign in_acc      = in_valid && !in_stall;
  assign out_acc     = out_valid && !out_stall;
  assign last_m_flag = (m_q == MW'(NUM_MOTORS - 1));

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      mmpd_pkg::ST_CLEAR:   if (clr_q == SW'(SD - 1)) st_d = mmpd_pkg::ST_IDLE;
      mmpd_pkg::ST_IDLE:
        if (in_acc && !in_data_i.kind) st_d = mmpd_pkg::ST_RD;
      mmpd_pkg::ST_RD:      st_d = on_m ? mmpd_pkg::ST_MUL : mmpd_pkg::ST_WB;
      mmpd_pkg::ST_MUL:     st_d = mmpd_pkg::ST_PD;
      mmpd_pkg::ST_PD:      st_d = mmpd_pkg::ST_SCALE;
      mmpd_pkg::ST_SCALE:   st_d = mmpd_pkg::ST_LOCKDIV;
      mmpd_pkg::ST_LOCKDIV: if (dv_done) st_d = mmpd_pkg::ST_FIN;
      mmpd_pkg::ST_FIN:     st_d = mmpd_pkg::ST_STDIV;
      mmpd_pkg::ST_STDIV:   if (dv_done) st_d = mmpd_pkg::ST_AVG;
      mmpd_pkg::ST_AVG:     st_d = mmpd_pkg::ST_WB;
      mmpd_pkg::ST_WB:
        st_d = last_m_flag ? mmpd_pkg::ST_OUT : mmpd_pkg::ST_RD;
      mmpd_pkg::ST_OUT:     if (!ov_q || out_acc) st_d = mmpd_pkg::ST_IDLE;
      default:              st_d = mmpd_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  logic signed [35:0] labs, fabs;
  logic [32:0]        dpos;
  always_comb begin
    in_stall = (st_q != mmpd_pkg::ST_IDLE);
    ram_we   = 1'b0;
    ram_wa   = slot;
    ram_wd   = stl_q;
    ram_ra   = slot;
    dv_start = 1'b0;
    labs     = (lsum_q < 0) ? -lsum_q : lsum_q;
    fabs     = '0;
    dpos     = (p_q < 0) ? 33'(-dx) : 33'(dx);
    dv_num   = 36'(labs);
    dv_den   = {33'b0, lcnt_q};
    case (st_q)
      mmpd_pkg::ST_CLEAR: begin
        ram_we = 1'b1; ram_wa = clr_q; ram_wd = '0;
      end
      mmpd_pkg::ST_SCALE: dv_start = 1'b1;
      mmpd_pkg::ST_FIN: begin
        dv_start = 1'b1;
        fabs     = (p_q < 0) ? 36'(-p_q) : 36'(p_q);
        dv_num   = fabs;
        dv_den   = ($signed(dpos) > 0) ? 36'(dpos) + 36'd1 : 36'd1;
      end
      mmpd_pkg::ST_AVG: ram_we = 1'b1;
      default: ;
    endcase
  end

  // datapath registers
  logic signed [48:0] pdc;
  logic signed [48:0] pdq;
  logic signed [36:0] lock_v, fin_v;
  logic [16:0]        nsum;
  logic signed [12:0] pdcl;
  logic [11:0]        pmag;
  logic [30:0]        sc_prod;
  logic [11:0]        sc_mag;
  logic               stop_c;
  always_comb begin
    pdc    = 49'(pkp_q) + 49'(pkd_q);
    pdq    = (pdc < 0) ? -((-pdc) >>> 6) : (pdc >>> 6);
    // clamp, then 0.9 scale as x * 471861 >> 19 (exact floor up to 2047)
    if (pd_q > $signed({38'b0, pwm_q}))       pdcl = $signed({2'b0, pwm_q});
    else if (pd_q < -$signed({38'b0, pwm_q})) pdcl = -$signed({2'b0, pwm_q});
    else                                      pdcl = pd_q[12:0];
    pmag    = (pdcl < 0) ? 12'(-pdcl) : 12'(pdcl);
    sc_prod = 31'(pmag) * 31'd471861;
    sc_mag  = sc_prod[30:19];
    lock_v = (lcnt_q == 0) ? 37'sd0 :
             (lneg_q ? -$signed({1'b0, dv_quo}) : $signed({1'b0, dv_quo}));
    fin_v  = 37'(sc_q) + lock_v;
    nsum   = ssum_q[m_q] - 17'(old_q) + 17'(stl_q);
    // average above the limit means sum >= depth * (limit + 1)
    stop_c = 18'(nsum) >= 18'(HISTORY_DEPTH) * (18'(slim_q) + 18'd1);
    ov_d   = ov_q;
    if (out_acc) ov_d = 1'b0;
    if (st_q == mmpd_pkg::ST_OUT && (!ov_q || out_acc)) ov_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= mmpd_pkg::ST_CLEAR;
      clr_q <= '0;
      m_q   <= '0;
      ov_q  <= 1'b0;
      for (int i = 0; i < NUM_MOTORS; i++) begin
        tgt_q[i] <= '0; last_q[i] <= '0; ridx_q[i] <= '0; ssum_q[i] <= '0;
      end
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
      case (st_q)
        mmpd_pkg::ST_CLEAR: clr_q <= clr_q + 1'b1;
        mmpd_pkg::ST_IDLE:
          if (in_acc && in_data_i.kind && in_data_i.target_motor < 3'(NUM_MOTORS)
              && en_q[in_data_i.target_motor]) begin
            if (in_data_i.target_value < 0)
              tgt_q[MW'(in_data_i.target_motor)] <= '0;
            else if (in_data_i.target_value > $signed({12'b0, maxt_q}))
              tgt_q[MW'(in_data_i.target_motor)] <= maxt_q;
            else
              tgt_q[MW'(in_data_i.target_motor)] <= in_data_i.target_value[19:0];
          end else if (in_acc) m_q <= '0;
        mmpd_pkg::ST_AVG: begin
          ssum_q[m_q] <= nsum;
          ridx_q[m_q] <= (ridx_q[m_q] == HW'(HISTORY_DEPTH - 1)) ? '0
                                                              : ridx_q[m_q] + 1'b1;
          last_q[m_q] <= pos_q[m_q];
        end
        mmpd_pkg::ST_WB: if (!last_m_flag) m_q <= m_q + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == mmpd_pkg::ST_IDLE && in_acc) begin
      pos_q[0] <= in_data_i.pos_m0;
      pos_q[1] <= in_data_i.pos_m1;
      if (NUM_MOTORS > 2) pos_q[2 % NUM_MOTORS] <= in_data_i.pos_m2;
      if (NUM_MOTORS > 3) pos_q[3 % NUM_MOTORS] <= in_data_i.pos_m3;
      if (NUM_MOTORS > 4) pos_q[4 % NUM_MOTORS] <= in_data_i.pos_m4;
      if (NUM_MOTORS > 5) pos_q[5 % NUM_MOTORS] <= in_data_i.pos_m5;
      flg_q <= '0;
      for (int i = 0; i < mmpd_pkg::MaxMotors; i++) drv_q[i] <= '0;
    end
    case (st_q)
      mmpd_pkg::ST_RD: begin
        pkp_q  <= 48'($signed({1'b0, kp_m}) * err);
        pkd_q  <= 48'($signed({1'b0, kd_m}) * derr);
        lsum_q <= lsum_c;
        lcnt_q <= lcnt_c;
        lneg_q <= lsum_c < 0;
      end
      mmpd_pkg::ST_MUL: pd_q <= pdq;
      mmpd_pkg::ST_PD:
        sc_q <= (pdcl < 0) ? -$signed({1'b0, sc_mag}) : $signed({1'b0, sc_mag});
      mmpd_pkg::ST_LOCKDIV: if (dv_done) begin
        fin_q <= fin_v;
        if (fin_v > $signed({26'b0, pwm_q}))       p_q <= $signed({1'b0, pwm_q});
        else if (fin_v < -$signed({26'b0, pwm_q})) p_q <= -$signed({1'b0, pwm_q});
        else p_q <= 12'(fin_v);
      end
      mmpd_pkg::ST_FIN: old_q <= ram_rd;
      mmpd_pkg::ST_STDIV: if (dv_done) stl_q <= 11'(dv_quo);
      mmpd_pkg::ST_AVG: begin
        if (stop_c) begin
          flg_q[m_q] <= 1'b1;
          drv_q[m_q] <= '0;
        end else if (fin_q > 37'sd2047)  drv_q[m_q] <= mmpd_pkg::DriveMax;
        else if (fin_q < -37'sd2047)     drv_q[m_q] <= -mmpd_pkg::DriveMax;
        else                             drv_q[m_q] <= 12'(fin_q);
      end
      default: ;
    endcase
    if (st_q == mmpd_pkg::ST_OUT && (!ov_q || out_acc)) begin
      res_q.drive_m0    <= drv_q[0];
      res_q.drive_m1    <= drv_q[1];
      res_q.drive_m2    <= drv_q[2];
      res_q.drive_m3    <= drv_q[3];
      res_q.drive_m4    <= drv_q[4];
      res_q.drive_m5    <= drv_q[5];
      res_q.stall_flags <= flg_q;
    end
  end

  assign out_valid  = ov_q;
  assign out_data_o = res_q;
endmodule
`default_nettype wire

@@ rtl/mmpd_checker.sv @@
// Port-level checker for the PD controller, bound to the top level.
// Depends on mmpd_pkg and the defines header.
`default_nettype none
`include "multi_motor_pd_with_lock_and_stall_top_defines.svh"
module mmpd_checker (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 in_valid,
  input wire                 in_stall,
  input wire                 out_valid,
  input wire                 out_stall,
  input mmpd_pkg::out_item_t out_data_o,
  input wire                 cfg_ready
);
  `MMPD_ASSERT(a_out_hold, clk_i, rst_ni, out_valid && out_stall |=> out_valid && $stable(out_data_o), "result dropped while stalled")
  `MMPD_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |=> !out_valid, "result during reset")
  `MMPD_ASSERT(a_cfg_rdy, clk_i, rst_ni, cfg_ready, "config port not ready")
  `MMPD_ASSERT(a_drive_rng, clk_i, rst_ni, out_valid |-> out_data_o.drive_m0 != 12'h800 && out_data_o.drive_m5 != 12'h800, "drive out of range")
endmodule
bind multi_motor_pd_with_lock_and_stall_top mmpd_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data_o(out_data_o),
  .cfg_ready(cfg_ready)
);
`default_nettype wire

@@ dv/multi_motor_pd_with_lock_and_stall_top_test.sv @@
// Self-checking testbench for the multi-motor PD controller with lock and stall cut-off.
// Drives ticks and target updates, predicts every result and compares it field by field.
// Depends on mmpd_pkg and multi_motor_pd_with_lock_and_stall_top.
`timescale 1ns / 1ps
module multi_motor_pd_with_lock_and_stall_top_test;

  localparam int CycleLimit = 4000000;
  localparam int SettleCycles = 800;
  localparam int HoldCycles = 4000;
  localparam int NMot = 6;
  localparam int HistDepth = 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  mmpd_pkg::in_item_t in_data_i = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  mmpd_pkg::out_item_t out_data_o;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index_i = mmpd_pkg::REG_ENABLE;
  logic [63:0] cfg_data_i = '0;

  multi_motor_pd_with_lock_and_stall_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid(in_valid), .in_stall(in_stall), .in_data_i(in_data_i),
    .out_valid(out_valid), .out_stall(out_stall), .out_data_o(out_data_o),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // predictor copy of registers and loop state
  logic [5:0]  en_mask = '0;
  logic [14:0] lk_mask = '0;
  logic [10:0] pwm_lim = 11'd512;
  logic [10:0] stall_lim = 11'd512;
  logic [19:0] max_tk = '0;
  logic [59:0] kp_tab = '0;
  logic [59:0] kd_tab = '0;
  logic [19:0] tgt_pos [NMot];
  longint      prev_pos [NMot];
  int unsigned stall_hist [NMot][HistDepth];
  int unsigned hist_ptr [NMot];
  int unsigned hist_sum [NMot];

  mmpd_pkg::in_item_t  pending_items[$];
  mmpd_pkg::out_item_t expected_drives[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int ticks_seen = 0;
  int stall_hits = 0;
  bit hold_arm = 0;
  bit hold_used = 0;
  int hold_left = 0;
  longint walk_pos [NMot];

  function automatic longint clamp_mag(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic bit pair_on(int a, int b);
    int i, j, bitn;
    i = a < b ? a : b;
    j = a < b ? b : a;
    bitn = i * (2 * NMot - i - 1) / 2 + (j - i - 1);
    return lk_mask[bitn];
  endfunction

  function automatic void predict_drives(mmpd_pkg::in_item_t it);
    longint pos [NMot];
    longint lim, kp, kd, err, derr, pd, scaled, lsum, lcnt, lock, fin, p, dx, den, stl, drv;
    int unsigned slot, avg;
    mmpd_pkg::out_item_t res;
    logic [11:0] drv_bits [NMot];
    if (it.kind) begin
      longint t;
      t = longint'(it.target_value);
      if (it.target_motor < NMot && en_mask[it.target_motor]) begin
        if (t < 0) t = 0;
        if (t > longint'(max_tk)) t = longint'(max_tk);
        tgt_pos[it.target_motor] = t[19:0];
      end
      return;
    end
    pos[0] = it.pos_m0; pos[1] = it.pos_m1; pos[2] = it.pos_m2;
    pos[3] = it.pos_m3; pos[4] = it.pos_m4; pos[5] = it.pos_m5;
    res = '0;
    lim = longint'(pwm_lim);
    for (int m = 0; m < NMot; m++) begin
      drv_bits[m] = '0;
      if (!en_mask[m]) continue;
      kp = longint'(kp_tab[10*m +: 10]);
      kd = longint'(kd_tab[10*m +: 10]);
      err = longint'(tgt_pos[m]) - pos[m];
      derr = prev_pos[m] - pos[m];
      pd = clamp_mag((kp * err + kd * derr) / 64, lim);
      scaled = (9 * pd) / 10;
      lsum = 0;
      lcnt = 0;
      for (int o = 0; o < NMot; o++) begin
        if (o == m || !en_mask[o] || !pair_on(m, o)) continue;
        lsum += pos[o] - pos[m];
        lcnt++;
      end
      lock = lcnt > 0 ? lsum / lcnt : 0;
      fin = scaled + lock;
      p = clamp_mag(fin, lim);
      dx = pos[m] - prev_pos[m];
      if (p < 0) dx = -dx;
      den = 1 + (dx > 0 ? dx : 0);
      stl = (p < 0 ? -p : p) / den;
      slot = hist_ptr[m] % HistDepth;
      hist_sum[m] = hist_sum[m] - stall_hist[m][slot] + int'(stl);
      stall_hist[m][slot] = int'(stl);
      hist_ptr[m] = (slot + 1) % HistDepth;
      prev_pos[m] = pos[m];
      avg = hist_sum[m] / HistDepth;
      if (avg > stall_lim) begin
        drv = 0;
        res.stall_flags[m] = 1'b1;
      end else begin
        drv = clamp_mag(fin, 2047);
      end
      drv_bits[m] = drv[11:0];
    end
    res.drive_m0 = drv_bits[0]; res.drive_m1 = drv_bits[1]; res.drive_m2 = drv_bits[2];
    res.drive_m3 = drv_bits[3]; res.drive_m4 = drv_bits[4]; res.drive_m5 = drv_bits[5];
    expected_drives.push_back(res);
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [63:0] val);
    case (idx)
      mmpd_pkg::REG_ENABLE: en_mask = val[5:0];
      mmpd_pkg::REG_LOCK:   lk_mask = val[14:0];
      mmpd_pkg::REG_PWM:    pwm_lim = val[10:0];
      mmpd_pkg::REG_STALL:  stall_lim = val[10:0];
      mmpd_pkg::REG_MAXT:   max_tk = val[19:0];
      mmpd_pkg::REG_KP:     kp_tab = val[59:0];
      mmpd_pkg::REG_KD:     kd_tab = val[59:0];
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // sender: one transfer per accepted item, payload held while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_drives(in_data_i);
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data_i <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result transfer, long hold-off once
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b1;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_drives.size() == 0) begin
          $error("result with no expectation pending");
          errors++;
        end else begin
          mmpd_pkg::out_item_t e;
          e = expected_drives.pop_front();
          ticks_seen++;
          if (out_data_o.stall_flags != 0) stall_hits++;
          check_field("drive_m0", e.drive_m0, out_data_o.drive_m0);
          check_field("drive_m1", e.drive_m1, out_data_o.drive_m1);
          check_field("drive_m2", e.drive_m2, out_data_o.drive_m2);
          check_field("drive_m3", e.drive_m3, out_data_o.drive_m3);
          check_field("drive_m4", e.drive_m4, out_data_o.drive_m4);
          check_field("drive_m5", e.drive_m5, out_data_o.drive_m5);
          check_field("stall_flags", e.stall_flags, out_data_o.stall_flags);
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (hold_arm && !hold_used) begin
        hold_used <= 1'b1;
        hold_left <= HoldCycles;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  int cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("multi_motor_pd_with_lock_and_stall_top regression: fail");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready);
    apply_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(logic [63:0] en, logic [63:0] lk, logic [63:0] pwm,
                           logic [63:0] stl, logic [63:0] mt, logic [63:0] kp,
                           logic [63:0] kd);
    write_reg(mmpd_pkg::REG_ENABLE, en);
    write_reg(mmpd_pkg::REG_LOCK, lk);
    write_reg(mmpd_pkg::REG_PWM, pwm);
    write_reg(mmpd_pkg::REG_STALL, stl);
    write_reg(mmpd_pkg::REG_MAXT, mt);
    write_reg(mmpd_pkg::REG_KP, kp);
    write_reg(mmpd_pkg::REG_KD, kd);
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_drives.size() > 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic mmpd_pkg::in_item_t tick_item(longint p0, longint p1, longint p2,
                                                   longint p3, longint p4, longint p5);
    mmpd_pkg::in_item_t it;
    it = '0;
    it.kind = 1'b0;
    it.target_motor = 3'($urandom_range(7));
    it.target_value = $urandom;
    it.pos_m0 = 32'(p0); it.pos_m1 = 32'(p1); it.pos_m2 = 32'(p2);
    it.pos_m3 = 32'(p3); it.pos_m4 = 32'(p4); it.pos_m5 = 32'(p5);
    return it;
  endfunction

  function automatic mmpd_pkg::in_item_t target_item(int mot, longint val);
    mmpd_pkg::in_item_t it;
    it = '0;
    it.kind = 1'b1;
    it.target_motor = 3'(mot);
    it.target_value = 32'(val);
    it.pos_m0 = $urandom; it.pos_m1 = $urandom; it.pos_m2 = $urandom;
    it.pos_m3 = $urandom; it.pos_m4 = $urandom; it.pos_m5 = $urandom;
    return it;
  endfunction

  // mostly a random walk that may freeze, so stall history builds up
  task automatic queue_random(int count);
    mmpd_pkg::in_item_t it;
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 30) begin
        if ($urandom_range(9) == 0)
          it = target_item($urandom_range(7), $signed($urandom));
        else
          it = target_item($urandom_range(7),
                           longint'($urandom_range(max_tk + 200)) - 100);
      end else begin
        for (int m = 0; m < NMot; m++) begin
          if ($urandom_range(19) == 0) walk_pos[m] = $signed($urandom);
          else if ($urandom_range(2) != 0)
            walk_pos[m] = walk_pos[m] + longint'($urandom_range(80)) - 40;
          walk_pos[m] = longint'(int'(walk_pos[m]));
        end
        it = tick_item(walk_pos[0], walk_pos[1], walk_pos[2],
                       walk_pos[3], walk_pos[4], walk_pos[5]);
      end
      pending_items.push_back(it);
    end
  endtask

  task automatic seed_walk();
    for (int m = 0; m < NMot; m++) walk_pos[m] = $urandom_range(max_tk);
  endtask

  initial begin
    for (int m = 0; m < NMot; m++) begin
      tgt_pos[m] = '0;
      prev_pos[m] = 0;
      hist_ptr[m] = 0;
      hist_sum[m] = 0;
      for (int k = 0; k < HistDepth; k++) stall_hist[m][k] = 0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset config: everything disabled, targets ignored
    pending_items.push_back(tick_item(1, -1, 2147483647, -2147483648, 0, 5));
    pending_items.push_back(target_item(0, 100));
    pending_items.push_back(tick_item(0, 0, 0, 0, 0, 0));
    drain();

    write_all(64'h3F, 64'h7FFF, 64'd2047, 64'd0, 64'd1000,
              {4'hF, 60'hFFFFFFFFFFFFFFF}, 64'h0FFFFFFFFFFFFFFF);
    pending_items.push_back(target_item(0, -5));
    pending_items.push_back(target_item(1, 5000));
    pending_items.push_back(target_item(2, 0));
    pending_items.push_back(target_item(3, 1000));
    pending_items.push_back(target_item(4, 2147483647));
    pending_items.push_back(target_item(5, -2147483648));
    pending_items.push_back(target_item(6, 77));
    pending_items.push_back(target_item(7, 88));
    pending_items.push_back(tick_item(2147483647, -2147483648, 0, -1, 1000, 5));
    pending_items.push_back(tick_item(-2147483648, 2147483647, 1, 0, -1000, 5));
    pending_items.push_back(tick_item(0, 0, 0, 0, 0, 0));
    pending_items.push_back(tick_item(0, 0, 0, 0, 0, 0));
    pending_items.push_back(tick_item(10, 20, 30, 40, 50, 60));
    pending_items.push_back(tick_item(-1, -1, -1, -1, -1, -1));
    drain();

    // pwm limit zero, motors 0 and 5 disabled
    write_all(64'h1E, 64'h0001, 64'd0, 64'd2047, 64'd0, 64'h0, 64'h0);
    pending_items.push_back(target_item(1, 999));
    pending_items.push_back(tick_item(5, -5, 7, -7, 9, -9));
    pending_items.push_back(tick_item(5, -5, 7, -7, 9, -9));
    drain();

    send_idle_pct = 33;
    recv_idle_pct = 46;
    write_all(64'h3F, $urandom_range(32767), 64'd2047, 64'd0, 64'd1048575,
              {$urandom, $urandom}, {$urandom, $urandom});
    seed_walk();
    queue_random(270);
    drain();

    send_idle_pct = 46;
    recv_idle_pct = 33;
    write_all($urandom_range(63), $urandom_range(32767), 64'd1, 64'd2047, 64'd0,
              64'hFFFFFFFFFFFFFFFF, 64'd0);
    seed_walk();
    queue_random(270);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_all(64'h3F, 64'h7FFF, 64'd300, 64'd40, 64'd5000,
              {$urandom, $urandom}, {$urandom, $urandom});
    seed_walk();
    hold_arm = 1;
    queue_random(270);
    drain();

    write_all($urandom, $urandom, $urandom_range(2047, 1), $urandom_range(200),
              $urandom, {$urandom, $urandom}, {$urandom, $urandom});
    seed_walk();
    queue_random(270);
    drain();

    $display("covered %0d tick results (%0d with a stall stop) over seven register settings",
             ticks_seen, stall_hits);
    if (errors == 0) begin
      $display("multi_motor_pd_with_lock_and_stall_top regression: pass");
    end else begin
      $display("multi_motor_pd_with_lock_and_stall_top regression: fail");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/mmpd_pkg.sv
rtl/mmpd_ram.sv
rtl/mmpd_div.sv
rtl/multi_motor_pd_with_lock_and_stall_top.sv
rtl/mmpd_checker.sv
dv/multi_motor_pd_with_lock_and_stall_top_test.sv
